// File: design/assert_macros.svh
// Assertion macros used by the request framer scanner RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// File: design/hrf_pkg.sv
// Types, codes and character constants of the HTTP request framer
package hrf_pkg;

   localparam int OUT_BITS = 21;
   localparam int CFG_BITS = 21;
   localparam logic [CFG_BITS-1:0] MAX_REQUEST_RESET = 21'd1048576;

   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_CLOSE = 1'b1;

   localparam logic [4:0] NAME_LEN       = 5'd15;
   localparam logic [4:0] POS_MISMATCH   = 5'd16;
   localparam logic [4:0] POS_LEADING_CR = 5'd17;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [23:0] TAIL_CRLFCR = 24'h0D0A0D;

   typedef enum logic [2:0] {
      VERDICT_COMPLETE            = 3'd0,
      VERDICT_CLOSED_AFTER_HEADER = 3'd1,
      VERDICT_BAD_LENGTH          = 3'd2,
      VERDICT_TOO_LARGE           = 3'd3,
      VERDICT_CLOSED_EARLY        = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      PHASE_IDLE      = 2'd0,
      PHASE_BLANKS    = 2'd1,
      PHASE_SIGN_SEEN = 2'd2,
      PHASE_DIGITS    = 2'd3
   } phase_type;

   typedef struct packed {
      logic       close;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      verdict_type         verdict;
      logic [OUT_BITS-1:0] head_size;
      logic [OUT_BITS-1:0] body_length;
      logic [OUT_BITS-1:0] bytes_received;
   } result_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? 8'(c + 8'd32) : c;
   endfunction

   // lower-case "content-length:"
   function automatic logic [7:0] name_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h63;
         4'd1:    ch = 8'h6F;
         4'd2:    ch = 8'h6E;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h65;
         4'd5:    ch = 8'h6E;
         4'd6:    ch = 8'h74;
         4'd7:    ch = 8'h2D;
         4'd8:    ch = 8'h6C;
         4'd9:    ch = 8'h65;
         4'd10:   ch = 8'h6E;
         4'd11:   ch = 8'h67;
         4'd12:   ch = 8'h74;
         4'd13:   ch = 8'h68;
         4'd14:   ch = 8'h3A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: design/hrf_in_reg.sv
// Input register stage of the request framer
module hrf_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [7:0]        req_data_byte,
   input  logic              advance,
   output logic              item_valid,
   output hrf_pkg::item_type item
);
   import hrf_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.close <= req_type;
         item_ff.data  <= req_data_byte;
      end
   end

endmodule

// File: design/hrf_scan.sv
// Per-byte header scanner, length parser and verdict logic
module hrf_scan #(
   parameter int COUNT_BITS = 21
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [hrf_pkg::CFG_BITS-1:0]    csr_wr_data,
   input  logic                            step,
   input  hrf_pkg::item_type               item,
   output logic                            emit,
   output hrf_pkg::result_type             result
);
   import hrf_pkg::*;
   `include "assert_macros.svh"

   localparam int CB1 = COUNT_BITS + 1;
   localparam int VB  = COUNT_BITS + 4;
   localparam logic [32:0] COUNT_MASK = (33'd1 << COUNT_BITS) - 33'd1;

   logic [CFG_BITS-1:0]   max_bytes_ff;
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [23:0]           tail_ff, tail_in;
   logic [4:0]            pos_ff, pos_in;
   logic                  line_start_ff, line_start_in;
   logic                  stopped_ff, stopped_in;
   phase_type             phase_ff, phase_in;
   logic                  negative_ff, negative_in;
   logic [COUNT_BITS-1:0] value_ff, value_in;
   logic                  found_ff, found_in;
   logic                  bad_ff, bad_in;
   logic                  hdr_done_ff, hdr_done_in;
   logic [CB1-1:0]        needed_ff, needed_in;

   logic [32:0]           cfg_ext;
   logic [32:0]           lim_ext;
   logic [COUNT_BITS-1:0] lim;

   assign cfg_ext = 33'(max_bytes_ff);
   assign lim_ext = (cfg_ext < COUNT_MASK) ? cfg_ext : COUNT_MASK;
   assign lim     = lim_ext[COUNT_BITS-1:0];

   always_comb begin
      logic [7:0]            c;
      logic [COUNT_BITS-1:0] count_inc;
      logic                  hdr_end;
      logic                  digit;
      logic [3:0]            d;
      logic [VB-1:0]         v_ext;
      logic [VB-1:0]         nv;
      logic [CB1-1:0]        needed;
      logic [COUNT_BITS-1:0] len;
      logic [CB1-1:0]        hb_wide;

      c         = item.data;
      count_inc = byte_count_ff + 1'b1;
      hdr_end   = 1'b0;
      digit     = (c >= CH_ZERO) && (c <= CH_NINE);
      d         = 4'(c - CH_ZERO);
      v_ext     = VB'(value_ff);
      nv        = (v_ext << 3) + (v_ext << 1) + VB'(d);
      needed    = '0;
      len       = '0;
      hb_wide   = '0;

      byte_count_in = byte_count_ff;
      tail_in       = tail_ff;
      pos_in        = pos_ff;
      line_start_in = line_start_ff;
      stopped_in    = stopped_ff;
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      value_in      = value_ff;
      found_in      = found_ff;
      bad_in        = bad_ff;
      hdr_done_in   = hdr_done_ff;
      needed_in     = needed_ff;

      emit                  = 1'b0;
      result.verdict        = VERDICT_COMPLETE;
      result.head_size      = '0;
      result.body_length    = '0;
      result.bytes_received = OUT_BITS'(byte_count_ff);

      if (item.close == REQ_CLOSE) begin
         emit = 1'b1;
         if (hdr_done_ff) begin
            result.verdict     = VERDICT_CLOSED_AFTER_HEADER;
            result.head_size   = OUT_BITS'(needed_ff - CB1'(value_ff));
            result.body_length = OUT_BITS'(value_ff);
         end else begin
            result.verdict = VERDICT_CLOSED_EARLY;
         end
      end else begin
         byte_count_in         = count_inc;
         result.bytes_received = OUT_BITS'(count_inc);
         if (!hdr_done_ff) begin
            hdr_end = (tail_ff == TAIL_CRLFCR) && (c == CH_LF);
            if (phase_ff != PHASE_IDLE) begin
               if (phase_ff == PHASE_BLANKS && (c == CH_SPACE || c == CH_TAB)) begin
                  phase_in = phase_ff;
               end else if (phase_ff == PHASE_BLANKS && (c == CH_PLUS || c == CH_MINUS)) begin
                  negative_in = (c == CH_MINUS);
                  phase_in    = PHASE_SIGN_SEEN;
               end else if (digit) begin
                  if (negative_ff && d != 4'd0) begin
                     bad_in = 1'b1;
                  end
                  if (nv > VB'(lim)) begin
                     bad_in   = 1'b1;
                     value_in = lim;
                  end else begin
                     value_in = nv[COUNT_BITS-1:0];
                  end
                  phase_in = PHASE_DIGITS;
               end else begin
                  if (phase_ff != PHASE_DIGITS) begin
                     bad_in = 1'b1;
                  end
                  phase_in = PHASE_IDLE;
               end
            end else if (!stopped_ff) begin
               if (c == CH_LF && tail_ff[7:0] == CH_CR) begin
                  // empty line ends the search for the length field
                  if (pos_ff == POS_LEADING_CR) begin
                     stopped_in = 1'b1;
                  end
                  pos_in        = '0;
                  line_start_in = 1'b1;
               end else begin
                  if (line_start_ff && c == CH_CR) begin
                     pos_in = POS_LEADING_CR;
                  end else if (pos_ff < NAME_LEN) begin
                     if (to_lower(c) == name_char(pos_ff[3:0])) begin
                        pos_in = 5'(pos_ff + 5'd1);
                        if (5'(pos_ff + 5'd1) == NAME_LEN) begin
                           stopped_in  = 1'b1;
                           found_in    = 1'b1;
                           phase_in    = PHASE_BLANKS;
                           negative_in = 1'b0;
                           value_in    = '0;
                        end
                     end else begin
                        pos_in = POS_MISMATCH;
                     end
                  end else begin
                     pos_in = POS_MISMATCH;
                  end
                  line_start_in = 1'b0;
               end
            end
            tail_in = {tail_ff[15:0], c};
            if (hdr_end) begin
               // the closing LF never touches the length state, so the held values serve
               result.head_size = OUT_BITS'(count_inc);
               if (bad_ff) begin
                  emit           = 1'b1;
                  result.verdict = VERDICT_BAD_LENGTH;
               end else begin
                  len    = found_ff ? value_ff : '0;
                  needed = CB1'(count_inc) + CB1'(len);
                  if (needed > CB1'(lim)) begin
                     emit               = 1'b1;
                     result.verdict     = VERDICT_TOO_LARGE;
                     result.body_length = OUT_BITS'(len);
                  end else if (CB1'(count_inc) >= needed) begin
                     emit               = 1'b1;
                     result.verdict     = VERDICT_COMPLETE;
                     result.body_length = OUT_BITS'(len);
                  end else begin
                     hdr_done_in = 1'b1;
                     needed_in   = needed;
                     value_in    = len;
                  end
               end
            end
         end else if (CB1'(count_inc) >= needed_ff) begin
            emit               = 1'b1;
            result.verdict     = VERDICT_COMPLETE;
            result.head_size   = OUT_BITS'(needed_ff - CB1'(value_ff));
            result.body_length = OUT_BITS'(value_ff);
         end
         // a header found on this byte leaves the count below the limit
         if (!emit && count_inc >= lim) begin
            emit           = 1'b1;
            result.verdict = VERDICT_TOO_LARGE;
            if (hdr_done_ff) begin
               hb_wide            = needed_ff - CB1'(value_ff);
               result.head_size   = OUT_BITS'(hb_wide);
               result.body_length = OUT_BITS'(value_ff);
            end else begin
               result.head_size   = '0;
               result.body_length = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_REQUEST_RESET;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && emit)) begin
         byte_count_ff <= '0;
         tail_ff       <= '0;
         pos_ff        <= '0;
         line_start_ff <= 1'b1;
         stopped_ff    <= 1'b0;
         phase_ff      <= PHASE_IDLE;
         negative_ff   <= 1'b0;
         value_ff      <= '0;
         found_ff      <= 1'b0;
         bad_ff        <= 1'b0;
         hdr_done_ff   <= 1'b0;
         needed_ff     <= '0;
      end else if (step) begin
         byte_count_ff <= byte_count_in;
         tail_ff       <= tail_in;
         pos_ff        <= pos_in;
         line_start_ff <= line_start_in;
         stopped_ff    <= stopped_in;
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         value_ff      <= value_in;
         found_ff      <= found_in;
         bad_ff        <= bad_in;
         hdr_done_ff   <= hdr_done_in;
         needed_ff     <= needed_in;
      end
   end

   `ASSERT_PROP(a_restart_after_verdict, clock, reset, step && emit |=> byte_count_ff == '0, "request state not cleared after a verdict")
   `ASSERT_PROP(a_complete_sum, clock, reset, step && emit && result.verdict == VERDICT_COMPLETE |-> result.bytes_received == result.head_size + result.body_length, "complete transaction size mismatch")
   `ASSERT_PROP(a_value_needs_name, clock, reset, phase_ff != PHASE_IDLE |-> found_ff, "value parse without a matched field name")
   `ASSERT_NEVER(a_body_without_parse, clock, reset, hdr_done_ff && phase_ff != PHASE_IDLE, "value parse still open past header end")

endmodule

// File: design/hrf_out_reg.sv
// Result register of the request framer
module hrf_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  hrf_pkg::result_type      result,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_verdict,
   output logic [hrf_pkg::OUT_BITS-1:0] rsp_head_size,
   output logic [hrf_pkg::OUT_BITS-1:0] rsp_body_length,
   output logic [hrf_pkg::OUT_BITS-1:0] rsp_bytes_received
);
   import hrf_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign room     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_verdict        = result_ff.verdict;
   assign rsp_head_size      = result_ff.head_size;
   assign rsp_body_length    = result_ff.body_length;
   assign rsp_bytes_received = result_ff.bytes_received;

endmodule

// File: design/http_request_framer_core.sv
// HTTP request framer top level: input register, byte scanner, result register
// Takes one request byte or connection-close event per transaction and gives one verdict per
// request (complete, closed after header, bad length, too large, closed before header end)
// with header size, Content-Length value and byte count. One transaction is accepted every
// cycle while the result register has room; a verdict is registered in the result register
// once the transaction that causes it leaves the input register, and while a verdict waits
// on rsp_ready the input is held. The rate is set by the update of the per-request scan
// state, which every byte reads and writes. The size limit csr_wr_data takes effect on the
// next byte and should be written between requests or while the block is idle.
module http_request_framer_core #(
   parameter int COUNT_BITS = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [7:0]                   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_verdict,
   output logic [hrf_pkg::OUT_BITS-1:0] rsp_head_size,
   output logic [hrf_pkg::OUT_BITS-1:0] rsp_body_length,
   output logic [hrf_pkg::OUT_BITS-1:0] rsp_bytes_received,
   input  logic                         csr_wr_en,
   input  logic [hrf_pkg::CFG_BITS-1:0] csr_wr_data
);
   import hrf_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       room;
   logic       advance;
   logic       emit;
   result_type result;

   assign advance = item_valid && room;

   hrf_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .item_valid    (item_valid),
      .item          (item)
   );

   hrf_scan #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .item        (item),
      .emit        (emit),
      .result      (result)
   );

   hrf_out_reg u_out_reg (
      .clock              (clock),
      .reset              (reset),
      .load               (advance && emit),
      .result             (result),
      .room               (room),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_head_size      (rsp_head_size),
      .rsp_body_length    (rsp_body_length),
      .rsp_bytes_received (rsp_bytes_received)
   );

endmodule

// File: sim/http_request_framer_core_test.sv
// Self-checking testbench for the HTTP request framer core: directed and random request streams
module http_request_framer_core_test;
   import hrf_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned MAX_WAIT       = 13;
   localparam int unsigned ITEM_TARGET    = 750;
   localparam logic [8*15-1:0] FIELD_NAME = "content-length:";
   localparam logic [7:0] CH_WRONG = 8'h71;
   localparam string FILLER = "abXYz: -9+";

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic                req_type      = REQ_DATA;
   logic [7:0]          req_data_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [2:0]          rsp_verdict;
   logic [OUT_BITS-1:0] rsp_head_size;
   logic [OUT_BITS-1:0] rsp_body_length;
   logic [OUT_BITS-1:0] rsp_bytes_received;
   logic                csr_wr_en     = 1'b0;
   logic [CFG_BITS-1:0] csr_wr_data   = '0;

   http_request_framer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_head_size      (rsp_head_size),
      .rsp_body_length    (rsp_body_length),
      .rsp_bytes_received (rsp_bytes_received),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   item_type    request_bytes[$];
   result_type  pending_verdicts[$];
   item_type    cur_item;
   int unsigned send_wait;
   int unsigned recv_wait;
   bit          sender_idle;
   bit          receiver_idle;
   int unsigned items_made;
   int unsigned error_count;

   // framer state as predicted
   logic [20:0] size_limit;
   logic [20:0] rx_count;
   logic [23:0] last_bytes;
   logic [4:0]  name_pos;
   logic        line_start;
   logic        scan_done;
   phase_type   num_phase;
   logic        num_negative;
   logic [20:0] num_value;
   logic        num_seen;
   logic        num_bad;
   logic        hdr_seen;
   logic [21:0] need_total;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void restart_scan();
      rx_count     = '0;
      last_bytes   = '0;
      name_pos     = '0;
      line_start   = 1'b1;
      scan_done    = 1'b0;
      num_phase    = PHASE_IDLE;
      num_negative = 1'b0;
      num_value    = '0;
      num_seen     = 1'b0;
      num_bad      = 1'b0;
      hdr_seen     = 1'b0;
      need_total   = '0;
   endfunction

   function automatic result_type close_out(verdict_type v, logic [20:0] hb, logic [20:0] body);
      result_type r;
      r.verdict        = v;
      r.head_size      = hb;
      r.body_length    = body;
      r.bytes_received = rx_count;
      restart_scan();
      return r;
   endfunction

   function automatic void number_step(logic [7:0] c);
      logic [31:0] nv;
      if (num_phase == PHASE_BLANKS && (c == CH_SPACE || c == CH_TAB))
         return;
      if (num_phase == PHASE_BLANKS && (c == CH_PLUS || c == CH_MINUS)) begin
         num_negative = (c == CH_MINUS);
         num_phase    = PHASE_SIGN_SEEN;
         return;
      end
      if (c >= CH_ZERO && c <= CH_NINE) begin
         nv = 32'(num_value) * 32'd10 + 32'(c - CH_ZERO);
         if (num_negative && c != CH_ZERO)
            num_bad = 1'b1;
         if (nv > 32'(size_limit)) begin
            num_bad = 1'b1;
            nv      = 32'(size_limit);
         end
         num_value = nv[20:0];
         num_phase = PHASE_DIGITS;
         return;
      end
      if (num_phase != PHASE_DIGITS)
         num_bad = 1'b1;
      num_phase = PHASE_IDLE;
   endfunction

   function automatic void name_step(logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
      if (c == CH_LF && last_bytes[7:0] == CH_CR) begin
         if (name_pos == POS_LEADING_CR)
            scan_done = 1'b1;
         name_pos   = '0;
         line_start = 1'b1;
         return;
      end
      if (line_start && c == CH_CR) begin
         name_pos = POS_LEADING_CR;
      end else if (name_pos < NAME_LEN) begin
         if (lc == FIELD_NAME[8*(14 - int'(name_pos)) +: 8]) begin
            name_pos = name_pos + 5'd1;
            if (name_pos == NAME_LEN) begin
               scan_done    = 1'b1;
               num_seen     = 1'b1;
               num_phase    = PHASE_BLANKS;
               num_negative = 1'b0;
               num_value    = '0;
            end
         end else begin
            name_pos = POS_MISMATCH;
         end
      end else begin
         name_pos = POS_MISMATCH;
      end
      line_start = 1'b0;
   endfunction

   function automatic bit frame_byte(input item_type it, output result_type r);
      logic       hdr_end;
      logic [7:0] c;
      r = '0;
      c = it.data;
      if (it.close == REQ_CLOSE) begin
         if (hdr_seen)
            r = close_out(VERDICT_CLOSED_AFTER_HEADER, 21'(need_total - num_value), num_value);
         else
            r = close_out(VERDICT_CLOSED_EARLY, '0, '0);
         return 1'b1;
      end
      rx_count = rx_count + 21'd1;
      if (!hdr_seen) begin
         hdr_end = (last_bytes == TAIL_CRLFCR) && c == CH_LF;
         if (num_phase != PHASE_IDLE)
            number_step(c);
         else if (!scan_done)
            name_step(c);
         last_bytes = {last_bytes[15:0], c};
         if (hdr_end) begin
            if (num_bad) begin
               r = close_out(VERDICT_BAD_LENGTH, rx_count, '0);
               return 1'b1;
            end
            if (!num_seen)
               num_value = '0;
            need_total = 22'(rx_count) + 22'(num_value);
            if (need_total > 22'(size_limit)) begin
               r = close_out(VERDICT_TOO_LARGE, rx_count, num_value);
               return 1'b1;
            end
            if (22'(rx_count) >= need_total) begin
               r = close_out(VERDICT_COMPLETE, rx_count, num_value);
               return 1'b1;
            end
            hdr_seen = 1'b1;
         end
      end else if (22'(rx_count) >= need_total) begin
         r = close_out(VERDICT_COMPLETE, 21'(need_total - num_value), num_value);
         return 1'b1;
      end
      if (rx_count >= size_limit) begin
         if (hdr_seen)
            r = close_out(VERDICT_TOO_LARGE, 21'(need_total - num_value), num_value);
         else
            r = close_out(VERDICT_TOO_LARGE, '0, '0);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // sender
   always @(posedge clock) begin : driver
      result_type outcome;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (frame_byte(cur_item, outcome))
               pending_verdicts.push_back(outcome);
            send_wait = sender_idle ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (!req_valid || req_ready) begin
            if (send_wait != 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (request_bytes.size() != 0) begin
               cur_item = request_bytes.pop_front();
               req_valid     <= 1'b1;
               req_type      <= cur_item.close;
               req_data_byte <= cur_item.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               flag_mismatch("unexpected verdict", 32'(rsp_verdict), 32'd0);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_verdict !== want.verdict)
                  flag_mismatch("verdict", 32'(rsp_verdict), 32'(want.verdict));
               if (rsp_head_size !== want.head_size)
                  flag_mismatch("head_size", 32'(rsp_head_size), 32'(want.head_size));
               if (rsp_body_length !== want.body_length)
                  flag_mismatch("body_length", 32'(rsp_body_length), 32'(want.body_length));
               if (rsp_bytes_received !== want.bytes_received)
                  flag_mismatch("bytes_received", 32'(rsp_bytes_received),
                                32'(want.bytes_received));
            end
            recv_wait = receiver_idle ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (recv_wait != 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   function automatic void push_item(logic close, logic [7:0] b);
      item_type it;
      it.close = close;
      it.data  = b;
      request_bytes.push_back(it);
      items_made++;
   endfunction

   function automatic void push_byte(logic [7:0] b);
      push_item(REQ_DATA, b);
   endfunction

   function automatic void push_close();
      push_item(REQ_CLOSE, 8'($urandom_range(0, 255)));
   endfunction

   function automatic void push_text(string s);
      int i;
      for (i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endfunction

   function automatic void push_crlf();
      push_byte(CH_CR);
      push_byte(CH_LF);
   endfunction

   function automatic void push_line(string s);
      push_text(s);
      push_crlf();
   endfunction

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0:       b = CH_CR;
         1:       b = CH_LF;
         default: b = 8'($urandom_range(0, 255));
      endcase
      return b;
   endfunction

   function automatic void filler_line();
      int unsigned n;
      int unsigned i;
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
         push_byte(FILLER[$urandom_range(0, FILLER.len() - 1)]);
         if (i == 0 && $urandom_range(0, 7) == 0)
            push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      end
      push_crlf();
   endfunction

   // field name in random case, now and then with one wrong letter
   function automatic bit length_name(bit may_corrupt);
      int unsigned bad_pos;
      int          i;
      logic [7:0]  ch;
      logic [7:0]  up;
      bad_pos = (may_corrupt && $urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : 15;
      for (i = 0; i < 15; i++) begin
         ch = FIELD_NAME[8*(14 - i) +: 8];
         up = ch - 8'd32;
         if (i == bad_pos)
            ch = CH_WRONG;
         else if (up >= CH_UP_A && up <= CH_UP_Z && $urandom_range(0, 1))
            ch = up;
         push_byte(ch);
      end
      return bad_pos < 15;
   endfunction

   function automatic void gen_request();
      int unsigned kind;
      int unsigned sign;
      int unsigned val;
      int unsigned body;
      bit          no_len;
      bit          has_digits;
      bit          cut;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         push_close();
         return;
      end
      if (kind == 1) begin
         repeat ($urandom_range(1, 12)) push_byte(noise_byte());
         push_close();
         return;
      end
      body   = 0;
      no_len = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
         push_crlf();
         no_len = 1'b1;
      end
      repeat ($urandom_range(0, 2)) filler_line();
      if ($urandom_range(0, 3) != 0) begin
         if (length_name(1'b1))
            no_len = 1'b1;
         repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         sign = $urandom_range(0, 7);
         if (sign == 0)
            push_byte(CH_PLUS);
         else if (sign == 1)
            push_byte(CH_MINUS);
         val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000000) : $urandom_range(0, 12);
         has_digits = ($urandom_range(0, 11) != 0);
         if (has_digits) begin
            if ($urandom_range(0, 4) == 0)
               push_byte(CH_ZERO);
            push_text($sformatf("%0d", val));
         end
         if ($urandom_range(0, 5) == 0)
            push_text(" x;");
         push_crlf();
         if (!no_len && has_digits && (sign != 1 || val == 0))
            body = val;
         if ($urandom_range(0, 5) == 0) begin
            void'(length_name(1'b0));
            push_line(" 9");
         end
      end
      if ($urandom_range(0, 2) == 0)
         filler_line();
      push_crlf();
      if (body > 64) begin
         push_close();
         return;
      end
      cut = ($urandom_range(0, 7) == 0);
      if (cut)
         body = $urandom_range(0, body);
      repeat (body) push_byte(8'($urandom_range(0, 255)));
      if (cut)
         push_close();
   endfunction

   function automatic logic [20:0] pick_limit();
      logic [20:0] v;
      case ($urandom_range(0, 9))
         0:       v = 21'd4;
         1:       v = MAX_REQUEST_RESET;
         2, 3:    v = 21'($urandom_range(5, 40));
         9:       v = 21'($urandom_range(401, 1048576));
         default: v = 21'($urandom_range(41, 400));
      endcase
      return v;
   endfunction

   // wait for every transaction and verdict to drain, then let the design settle
   task automatic settle();
      @(negedge clock);
      while (request_bytes.size() != 0 || req_valid || pending_verdicts.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_limit(logic [20:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      size_limit = v;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int k;
      error_count   = 0;
      items_made    = 0;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      size_limit    = MAX_REQUEST_RESET;
      restart_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, limit at its reset value
      push_close();
      push_crlf(); push_crlf();
      push_line("A"); push_line("Content-Length: 3"); push_crlf(); push_text("xyz");
      push_text("cOnTeNt-LeNgTh:"); push_byte(CH_TAB); push_line(" +0"); push_crlf();
      push_line("Content-Length: -0"); push_crlf();
      push_line("Content-Length: -5"); push_crlf();
      push_line("Content-Length: "); push_crlf();
      push_line("Content-Length: 2abc"); push_crlf(); push_text("hi");
      push_line("Content-Length: 99999999"); push_crlf();
      push_line("X: 1"); push_line("Content-Length: 2"); push_line("Content-Length: 7");
      push_crlf(); push_text("ab");
      push_crlf(); push_line("Content-Length: 5"); push_crlf();
      push_line("Content-Length: 4"); push_crlf(); push_text("ab"); push_close();
      push_text("GET"); push_close();
      push_byte(8'h00); push_crlf(); push_crlf();
      push_line("Content-Length: 1048576"); push_crlf();
      push_line("Content-Length: 1048577"); push_crlf();
      push_line("Content-Length:5"); push_crlf();
      for (k = 0; k < 5; k++)
         push_byte(8'hFF);
      settle();

      set_limit(21'd4);
      push_text("abcd");
      push_crlf(); push_crlf();
      push_text("ab"); push_close();
      settle();

      set_limit(MAX_REQUEST_RESET);
      push_line("Content-Length: 1048549"); push_crlf(); push_close();
      push_line("Content-Length: 1048550"); push_crlf();
      settle();

      while (items_made < ITEM_TARGET) begin
         set_limit(pick_limit());
         sender_idle   = ($urandom_range(0, 2) != 0);
         receiver_idle = ($urandom_range(0, 2) != 0);
         repeat (4) gen_request();
         push_close();
         settle();
      end

      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/hrf_pkg.sv
design/hrf_in_reg.sv
design/hrf_scan.sv
design/hrf_out_reg.sv
design/http_request_framer_core.sv
sim/http_request_framer_core_test.sv
